### rtl/hfsi_pkg.sv
// ----------------------------------------------------------------------------
// hfsi_pkg: shared types and codes for the heater/fan safety interlock
// Transaction structs, configuration and state records, opcodes, alarm codes.
// ----------------------------------------------------------------------------
package hfsi_pkg;

   // Opcodes
   localparam logic [3:0] OP_FAN_REQ     = 4'd0;
   localparam logic [3:0] OP_HEATER_REQ  = 4'd1;
   localparam logic [3:0] OP_SAMPLE      = 4'd2;
   localparam logic [3:0] OP_FAN_FAULT   = 4'd3;
   localparam logic [3:0] OP_DURATION    = 4'd4;
   localparam logic [3:0] OP_RECOV_SENS  = 4'd5;
   localparam logic [3:0] OP_ESTOP       = 4'd6;
   localparam logic [3:0] OP_ACK         = 4'd7;
   localparam logic [3:0] OP_QUERY       = 4'd8;

   // Alarm codes
   localparam logic [2:0] ALARM_NONE     = 3'd0;
   localparam logic [2:0] ALARM_SENSOR   = 3'd1;
   localparam logic [2:0] ALARM_CUTOFF   = 3'd2;
   localparam logic [2:0] ALARM_FAN      = 3'd3;
   localparam logic [2:0] ALARM_DURATION = 3'd4;
   localparam logic [2:0] ALARM_ESTOP    = 3'd5;

   // Status codes
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // CSR indexes
   localparam logic [1:0] CSR_FAN_FLOOR = 2'd0;
   localparam logic [1:0] CSR_CUTOFF    = 2'd1;
   localparam logic [1:0] CSR_WARNING   = 2'd2;
   localparam logic [1:0] CSR_FAN_STOP  = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // CSR reset values
   localparam logic [6:0]         FAN_FLOOR_RST = 7'd30;
   localparam logic signed [15:0] CUTOFF_RST    = 16'sd4160;
   localparam logic signed [15:0] WARNING_RST   = 16'sd3840;
   localparam logic signed [15:0] FAN_STOP_RST  = 16'sd800;

   localparam logic [6:0] PCT_MAX = 7'd100;

   typedef struct packed {
      logic [3:0]         opcode;
      logic [6:0]         pct;
      logic signed [15:0] temperature;
      logic               sample_valid;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [6:0] fan_level;
      logic [6:0] heater_level;
      logic [2:0] alarm_code;
      logic       needs_ack;
      logic       temp_warning;
   } rsp_type;

   typedef struct packed {
      logic [6:0]         fan_floor_pct;
      logic signed [15:0] cutoff_temp;
      logic signed [15:0] warning_temp;
      logic signed [15:0] fan_stop_temp;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         active_alarm;
      logic               ack_pending;
      logic               last_valid;
      logic signed [15:0] last_temp;
      logic [6:0]         fan_cmd;
      logic [6:0]         heater_cmd;
   } state_type;

endpackage

### rtl/hfsi_csr.sv
// ----------------------------------------------------------------------------
// hfsi_csr: configuration registers
// Write-only thresholds and fan floor, loaded from the CSR write port.
// ----------------------------------------------------------------------------
module hfsi_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [hfsi_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hfsi_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output hfsi_pkg::cfg_type                   cfg
);
   import hfsi_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FAN_FLOOR: cfg_in.fan_floor_pct = csr_wdata[6:0];
            CSR_CUTOFF:    cfg_in.cutoff_temp   = $signed(csr_wdata[15:0]);
            CSR_WARNING:   cfg_in.warning_temp  = $signed(csr_wdata[15:0]);
            CSR_FAN_STOP:  cfg_in.fan_stop_temp = $signed(csr_wdata[15:0]);
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fan_floor_pct <= FAN_FLOOR_RST;
         cfg_ff.cutoff_temp   <= CUTOFF_RST;
         cfg_ff.warning_temp  <= WARNING_RST;
         cfg_ff.fan_stop_temp <= FAN_STOP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/hfsi_eval.sv
// ----------------------------------------------------------------------------
// hfsi_eval: interlock rules
// Evaluates one event against the current state; gives next state and result.
// ----------------------------------------------------------------------------
module hfsi_eval (
   input  hfsi_pkg::req_type   req,
   input  hfsi_pkg::cfg_type   cfg,
   input  hfsi_pkg::state_type cur,
   output hfsi_pkg::state_type nxt,
   output hfsi_pkg::rsp_type   rsp
);
   import hfsi_pkg::*;

   function automatic state_type raise_alarm(input state_type s, input logic [2:0] code);
      state_type r;
      r              = s;
      r.heater_cmd   = '0;
      r.active_alarm = code;
      r.ack_pending  = 1'b1;
      return r;
   endfunction

   logic status;
   logic warn;
   logic pct_zero;
   logic pct_over;
   logic below_floor;
   logic fan_below_floor;
   logic cool_ok;
   logic at_cutoff;
   logic at_warning;

   assign pct_zero        = (req.pct == 7'd0);
   assign pct_over        = (req.pct > PCT_MAX);
   assign below_floor     = (req.pct < cfg.fan_floor_pct);
   assign fan_below_floor = (cur.fan_cmd < cfg.fan_floor_pct);
   // fan may stop only with a valid sample below the stop level
   assign cool_ok    = cur.last_valid && ($signed(cur.last_temp) < $signed(cfg.fan_stop_temp));
   assign at_cutoff  = $signed(req.temperature) >= $signed(cfg.cutoff_temp);
   assign at_warning = $signed(req.temperature) >= $signed(cfg.warning_temp);

   always_comb begin
      nxt    = cur;
      status = STATUS_OK;
      warn   = 1'b0;
      case (req.opcode)
         OP_FAN_REQ: begin
            if (cur.ack_pending) begin
               status = STATUS_REJECT;
            end else if (pct_zero && !cool_ok) begin
               status = STATUS_REJECT;
            end else if ((cur.heater_cmd != 7'd0) && below_floor) begin
               status = STATUS_REJECT;
            end else if (pct_over) begin
               status = STATUS_REJECT;
            end else begin
               nxt.fan_cmd = req.pct;
            end
         end
         OP_HEATER_REQ: begin
            if (cur.ack_pending) begin
               status = STATUS_REJECT;
            end else if (!pct_zero && (fan_below_floor || !cur.last_valid)) begin
               status = STATUS_REJECT;
            end else if (pct_over) begin
               status = STATUS_REJECT;
            end else begin
               nxt.heater_cmd = req.pct;
            end
         end
         OP_SAMPLE: begin
            nxt.last_temp  = req.temperature;
            nxt.last_valid = req.sample_valid;
            if (!req.sample_valid) begin
               if (cur.heater_cmd != 7'd0) begin
                  nxt = raise_alarm(nxt, ALARM_SENSOR);
               end
            end else if (at_cutoff) begin
               nxt = raise_alarm(nxt, ALARM_CUTOFF);
            end else if (at_warning && (cur.active_alarm == ALARM_NONE)) begin
               warn = 1'b1;
            end
         end
         OP_FAN_FAULT:  nxt = raise_alarm(cur, ALARM_FAN);
         OP_DURATION:   nxt = raise_alarm(cur, ALARM_DURATION);
         OP_RECOV_SENS: nxt = raise_alarm(cur, ALARM_SENSOR);
         OP_ESTOP:      nxt = raise_alarm(cur, ALARM_ESTOP);
         OP_ACK: begin
            if (!cur.ack_pending) begin
               status = STATUS_REJECT;
            end else begin
               nxt.ack_pending  = 1'b0;
               nxt.active_alarm = ALARM_NONE;
            end
         end
         OP_QUERY: begin
            status = STATUS_OK;
         end
         default: begin
            status = STATUS_REJECT;
         end
      endcase
   end

   always_comb begin
      rsp.status       = status;
      rsp.fan_level    = nxt.fan_cmd;
      rsp.heater_level = nxt.heater_cmd;
      rsp.alarm_code   = nxt.active_alarm;
      rsp.needs_ack    = nxt.ack_pending;
      rsp.temp_warning = warn;
   end

endmodule

### rtl/heater_fan_safety_interlock.sv
// ----------------------------------------------------------------------------
// heater_fan_safety_interlock: heater and fan command interlock
// Path: input reg, then result reg, from req acceptance to rsp_valid.
// Throughput: one transaction per cycle unless rsp_ready stalls; the rules
// logic between the registers updates state in the same cycle it forms a result.
// Reset (synchronous, active high): no alarm, no ack pending, no valid sample,
// fan and heater at 0, thresholds at their defaults; both stages emptied.
// ----------------------------------------------------------------------------
module heater_fan_safety_interlock (
   input  logic                                clock,
   input  logic                                reset,
   // event channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  hfsi_pkg::req_type                   req,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output hfsi_pkg::rsp_type                   rsp,
   // configuration write port
   input  logic                                csr_we,
   input  logic [hfsi_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hfsi_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import hfsi_pkg::*;

   cfg_type   cfg;

   // Input stage: holds one accepted transaction until it is evaluated.
   logic      in_valid_ff;
   req_type   in_ff;

   // Interlock state, updated as a transaction moves into the result stage.
   state_type state_ff;
   state_type state_in;

   // Result stage: doubles as the skid between the rules and the consumer.
   logic      out_valid_ff;
   rsp_type   out_ff;
   rsp_type   rsp_in;

   logic      advance;

   // The result register can take a new result when empty or being drained.
   // The input register refills whenever it empties or moves forward, so a
   // transaction can enter every cycle while the consumer keeps up.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   hfsi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hfsi_eval u_eval (
      .req (in_ff),
      .cfg (cfg),
      .cur (state_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req;
      end
      if (advance) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

### rtl/hfsi_checker.sv
// ----------------------------------------------------------------------------
// hfsi_checker: port-level assertions for the interlock
// Watches the result channel for handshake and safety invariants.
// ----------------------------------------------------------------------------
module hfsi_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hfsi_pkg::rsp_type rsp
);
   import hfsi_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("result changed while stalled");

   // heater is off whenever an alarm awaits acknowledge
   a_trip_heater_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.needs_ack |-> rsp.heater_level == 7'd0)
      else $error("heater on while safety tripped");

   // alarm code and ack flag move together
   a_alarm_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.needs_ack == (rsp.alarm_code != ALARM_NONE))
      else $error("alarm code and needs_ack disagree");

   // a warning only with no alarm and an ok status
   a_warn_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.temp_warning |->
         rsp.alarm_code == ALARM_NONE && rsp.status == STATUS_OK)
      else $error("warning raised with alarm active");

endmodule

bind heater_fan_safety_interlock hfsi_checker u_hfsi_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);
